// ===== rtl/core/lrubc_pkg.sv =====
// lrubc_pkg: shared constants for the lru block cache replacement core
// no dependencies; imported by lru_block_cache_replacement_core
package lrubc_pkg;

    // fixed widths of the result fields
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned VICTIM_W = 20;

endpackage

// ===== rtl/core/lru_block_cache_replacement_core.sv =====
// lru_block_cache_replacement_core: lru slot selection for a block cache
// entry table in one synchronous memory, valid bits in flops
// depends on lrubc_pkg
//
//  channel   signals                                      direction
//  -------   -------------------------------------------  ---------
//  in        in_valid, in_stall, block_number             request in
//  out       out_valid, out_stall, hit, slot,             result out
//            victim_valid, victim_block
//  cfg       cfg_valid, cfg_ready, cfg_data (pinned)      write in
//
// one request at a time: the scan reads one entry a cycle through the single memory
// read port, then the entry is written back in S_DONE; in_stall is high until then.
// reset clears the valid bits, the time counter and the control; pinned block resets to 1.
// a new request is taken while a finished result waits in the output register;
// the write-back waits only while that register is still full and stalled.
// the pinned register takes writes only while no request is being scanned
module lru_block_cache_replacement_core
    import lrubc_pkg::*;
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned BLOCK_BITS = 20,
    parameter int unsigned TIME_BITS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BLOCK_BITS-1:0] block_number,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [SLOT_W-1:0]     slot,
    output logic                  victim_valid,
    output logic [VICTIM_W-1:0]   victim_block,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BLOCK_BITS-1:0] cfg_data
);

    localparam int unsigned IDX_W  = $clog2(ENTRIES);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned WORD_W = BLOCK_BITS + TIME_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // entry memory: {block, stamp}
    logic [WORD_W-1:0]     mem [ENTRIES];
    logic [WORD_W-1:0]     mem_q_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;

    state_t                state_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [BLOCK_BITS-1:0] pinned_reg;
    logic [BLOCK_BITS-1:0] blk_reg;
    logic [CNT_W-1:0]      rd_cnt_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;

    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  found_reg;
    logic [TIME_BITS-1:0]  best_age_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic                  best_valid_reg;
    logic [BLOCK_BITS-1:0] best_blk_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  victim_valid_reg;
    logic [VICTIM_W-1:0]   victim_block_reg;

    // scan evaluation
    logic                  e_valid;
    logic [BLOCK_BITS-1:0] e_blk;
    logic [TIME_BITS-1:0]  e_stamp;
    logic [TIME_BITS-1:0]  e_age;
    logic                  e_match;
    logic                  e_pinned;
    logic                  e_first;
    logic                  e_take;
    logic                  rd_more;
    logic                  done_go;
    logic [SLOT_W+IDX_W-1:0]        slot_ext;
    logic [VICTIM_W+BLOCK_BITS-1:0] vblk_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign e_valid  = valid_reg[rd_idx_reg];
    assign e_blk    = mem_q_reg[WORD_W-1:TIME_BITS];
    assign e_stamp  = mem_q_reg[TIME_BITS-1:0];
    assign e_age    = e_valid ? (time_reg - e_stamp) : time_reg;
    assign e_match  = e_valid && (e_blk == blk_reg);
    assign e_pinned = e_valid && (pinned_reg != '0) && (e_blk == pinned_reg);
    assign e_first  = (rd_idx_reg == '0);
    assign e_take   = e_first || (!e_pinned && (!found_reg || (e_age > best_age_reg)));

    assign rd_more   = (rd_cnt_reg < CNT_W'(ENTRIES));
    assign mem_raddr = rd_cnt_reg[IDX_W-1:0];
    assign done_go   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign mem_we    = done_go;
    assign mem_waddr = hit_found_reg ? hit_idx_reg : best_idx_reg;

    assign slot_ext = {{SLOT_W{1'b0}}, mem_waddr};
    assign vblk_ext = {{VICTIM_W{1'b0}}, best_blk_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {blk_reg, time_reg};
        end
        mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            time_reg         <= '0;
            pinned_reg       <= BLOCK_BITS'(1);
            blk_reg          <= '0;
            rd_cnt_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            hit_found_reg    <= 1'b0;
            hit_idx_reg      <= '0;
            found_reg        <= 1'b0;
            best_age_reg     <= '0;
            best_idx_reg     <= '0;
            best_valid_reg   <= 1'b0;
            best_blk_reg     <= '0;
            out_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            slot_reg         <= '0;
            victim_valid_reg <= 1'b0;
            victim_block_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pinned_reg <= cfg_data;
            end

            if (out_valid_reg && !out_stall && !done_go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (in_valid)
                    begin
                        blk_reg    <= block_number;
                        time_reg   <= time_reg + 1'b1;
                        rd_cnt_reg <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // issue one read a cycle, evaluate the entry read last cycle
                    rd_vld_reg <= rd_more;
                    rd_idx_reg <= mem_raddr;
                    if (rd_more)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        if (e_match && (e_first || !hit_found_reg))
                        begin
                            hit_idx_reg <= rd_idx_reg;
                        end
                        hit_found_reg <= e_first ? e_match : (hit_found_reg || e_match);
                        found_reg     <= e_first ? !e_pinned : (found_reg || !e_pinned);
                        if (e_take)
                        begin
                            best_age_reg   <= e_age;
                            best_idx_reg   <= rd_idx_reg;
                            best_valid_reg <= e_valid;
                            best_blk_reg   <= e_blk;
                        end
                        if (rd_idx_reg == IDX_W'(ENTRIES - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (done_go)
                    begin
                        valid_reg[mem_waddr] <= 1'b1;
                        out_valid_reg        <= 1'b1;
                        hit_reg              <= hit_found_reg;
                        slot_reg             <= slot_ext[SLOT_W-1:0];
                        victim_valid_reg     <= !hit_found_reg && best_valid_reg;
                        victim_block_reg     <= (!hit_found_reg && best_valid_reg)
                                                ? vblk_ext[VICTIM_W-1:0] : '0;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign victim_valid = victim_valid_reg;
    assign victim_block = victim_block_reg;

endmodule
